// ===== sv/qcr_pkg.sv =====
`default_nettype none

package qcr_pkg;

    // counts per second scale applied to the count change before dividing
    localparam int TICKS_PER_SECOND = 1000;
    localparam int TICK_W           = $clog2(TICKS_PER_SECOND + 1);
    // magnitude of count change times ticks, also the divider width
    localparam int MAG_W            = 32 + TICK_W;
    localparam int CNT_W            = $clog2(MAG_W);

    localparam logic [1:0] OP_CHANGE_A = 2'd0;
    localparam logic [1:0] OP_CHANGE_B = 2'd1;
    localparam logic [1:0] OP_MEASURE  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic        level_a;
        logic        level_b;
        logic [31:0] time_ms;
    } qcr_in_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] rate_pps;
        logic               rate_valid;
        logic               zero_interval;
    } qcr_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } qcr_state_t;

    typedef struct packed {
        logic step_load;
        logic meas_start;
        logic mul_load;
        logic div_step;
        logic finish_load;
    } qcr_cmd_t;

    typedef struct packed {
        logic interval_zero;
        logic div_last;
    } qcr_status_t;

endpackage

`default_nettype wire

// ===== sv/quadrature_counter_with_rate_unit.sv =====
`default_nettype none

// x4 quadrature decoder with a rate meter. every request gives exactly one
// result. a channel A or B change request (or the unused operation code,
// which changes nothing) is accepted and its result is in the
// output register on the next cycle. a measure request computes
// (count change since last measure) * TICKS_PER_SECOND / (elapsed ms),
// truncated toward zero and saturated to 32 bits. the result comes from
// the bit-serial restoring divider in the datapath, which retires one
// quotient bit per cycle over a MAG_W-bit dividend. a zero interval skips
// the divider and finishes with a rate of 0 and the zero_interval flag.
// only one request is in flight at a time; a new one is taken while
// the previous result still waits in the output register, as long as that
// register is about to be freed. the count wraps modulo 2^32 and the
// millisecond timestamp difference is taken modulo 2^32.

module quadrature_counter_with_rate_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire qcr_pkg::qcr_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output qcr_pkg::qcr_out_t      out_data
);
    import qcr_pkg::*;

    // command and status between the sequencer and the datapath
    qcr_cmd_t    cmd;
    qcr_status_t status;

    // sequencer: request handshake, measure sequencing, output valid
    qcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (in_data.operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: counter, measure snapshot, multiply, divide, saturate
    qcr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

// ===== sv/qcr_ctrl.sv =====
`default_nettype none

module qcr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          operation,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire qcr_pkg::qcr_status_t status,
    output qcr_pkg::qcr_cmd_t        cmd
);
    import qcr_pkg::*;

    qcr_state_t state_reg;
    qcr_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;
    logic       accept;

    assign slot_free = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == OP_MEASURE)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = status.interval_zero ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = slot_free;
                cmd.step_load  = in_valid && slot_free && operation != OP_MEASURE;
                cmd.meas_start = in_valid && slot_free && operation == OP_MEASURE;
            end
            ST_MUL:    cmd.mul_load    = 1'b1;
            ST_DIV:    cmd.div_step    = 1'b1;
            ST_FINISH: cmd.finish_load = slot_free;
            default:   cmd             = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.step_load || cmd.finish_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/qcr_dp.sv =====
`default_nettype none

module qcr_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire qcr_pkg::qcr_in_t    in_data,
    input  wire qcr_pkg::qcr_cmd_t   cmd,
    output qcr_pkg::qcr_status_t     status,
    output qcr_pkg::qcr_out_t        out_data
);
    import qcr_pkg::*;

    localparam logic [TICK_W-1:0] TICKS_C  = TICK_W'(TICKS_PER_SECOND);
    localparam logic [MAG_W-1:0]  POS_MAX  = {{(MAG_W-32){1'b0}}, 32'h7fff_ffff};
    localparam logic [MAG_W-1:0]  NEG_MAX  = {{(MAG_W-32){1'b0}}, 32'h8000_0000};

    // architectural state
    logic [31:0]      count_reg;
    logic [31:0]      count_next;
    logic [31:0]      base_count_reg;
    logic [31:0]      base_time_reg;
    logic [31:0]      rate_reg;
    logic [31:0]      rate_next;
    // measure working registers
    logic             zero_reg;
    logic             neg_reg;
    logic [31:0]      mag_reg;
    logic [31:0]      div_reg;
    logic [MAG_W-1:0] dq_reg;
    logic [31:0]      rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    qcr_out_t         out_reg;

    logic [31:0]      delta;
    logic [31:0]      interval;
    logic             step_up;
    logic             step_en;
    logic [32:0]      shifted;
    logic [33:0]      trial;
    logic             ge;
    logic [31:0]      rate_sat;

    assign delta    = count_reg - base_count_reg;
    assign interval = in_data.time_ms - base_time_reg;

    // quadrature step direction
    always_comb
    begin
        step_up = 1'b0;
        step_en = 1'b0;
        case (in_data.operation)
            OP_CHANGE_A:
            begin
                step_en = 1'b1;
                step_up = in_data.level_a ^ in_data.level_b;
            end
            OP_CHANGE_B:
            begin
                step_en = 1'b1;
                step_up = ~(in_data.level_a ^ in_data.level_b);
            end
            default:
            begin
                step_en = 1'b0;
                step_up = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (!step_en)
            count_next = count_reg;
        else if (step_up)
            count_next = count_reg + 32'd1;
        else
            count_next = count_reg - 32'd1;
    end

    // one restoring division step
    assign shifted = {rem_reg, dq_reg[MAG_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, div_reg};
    assign ge      = !trial[33];

    // sign and saturation of the quotient magnitude
    always_comb
    begin
        if (neg_reg)
            rate_sat = (dq_reg > NEG_MAX) ? 32'h8000_0000 : (32'd0 - dq_reg[31:0]);
        else
            rate_sat = (dq_reg > POS_MAX) ? 32'h7fff_ffff : dq_reg[31:0];
    end

    assign rate_next = zero_reg ? 32'd0 : rate_sat;

    assign status.interval_zero = zero_reg;
    assign status.div_last      = (cnt_reg == CNT_W'(MAG_W - 1));
    assign out_data             = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            base_count_reg <= '0;
            base_time_reg  <= '0;
            rate_reg       <= '0;
            zero_reg       <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cmd.step_load)
                count_reg <= count_next;
            if (cmd.meas_start)
            begin
                base_count_reg <= count_reg;
                base_time_reg  <= in_data.time_ms;
                zero_reg       <= (interval == 32'd0);
            end
            if (cmd.mul_load)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.finish_load)
                rate_reg <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.meas_start)
        begin
            neg_reg <= delta[31];
            mag_reg <= delta[31] ? (32'd0 - delta) : delta;
            div_reg <= interval;
        end
        if (cmd.mul_load)
        begin
            dq_reg  <= {{TICK_W{1'b0}}, mag_reg} * {{32{1'b0}}, TICKS_C};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[MAG_W-2:0], ge};
            rem_reg <= ge ? trial[31:0] : shifted[31:0];
        end
        if (cmd.step_load)
        begin
            out_reg.position      <= count_next;
            out_reg.rate_pps      <= rate_reg;
            out_reg.rate_valid    <= 1'b0;
            out_reg.zero_interval <= 1'b0;
        end
        else if (cmd.finish_load)
        begin
            out_reg.position      <= count_reg;
            out_reg.rate_pps      <= rate_next;
            out_reg.rate_valid    <= !zero_reg;
            out_reg.zero_interval <= zero_reg;
        end
    end

endmodule

`default_nettype wire

// ===== sv/qcr_checker.sv =====
`default_nettype none

module qcr_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire qcr_pkg::qcr_in_t  in_data,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire qcr_pkg::qcr_out_t out_data
);
    import qcr_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // the two measure flags never show together
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.rate_valid && out_data.zero_interval))
        else $error("rate_valid and zero_interval both set");

    // a zero interval reports a zero rate
    a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_interval |-> out_data.rate_pps == 32'sd0)
        else $error("zero interval with nonzero rate");

    // a channel change request gives its result on the next cycle
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready &&
        (in_data.operation == OP_CHANGE_A || in_data.operation == OP_CHANGE_B)
        |=> out_valid && !out_data.rate_valid && !out_data.zero_interval)
        else $error("channel change result missing");

endmodule

bind quadrature_counter_with_rate_unit qcr_checker u_qcr_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;

    import qcr_pkg::*;

    // operation code the block must ignore, absent from the package
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // saturation limits for the measured rate
    localparam longint RATE_MAX = 64'sd2147483647;
    localparam longint RATE_MIN = -64'sd2147483648;

    // cycles to keep watching after the last result
    localparam int DRAIN_CYCLES = 60;

    // length of the single long receiver hold-off
    localparam int HOLD_OFF_CYCLES = 400;

    // random requests per idling phase, five phases in all
    localparam int PHASE_ITEMS = 215;

    // tracks count, last measure and held rate; queues the result each request must give
    class position_rate_tracker;
        logic [31:0] pulse_count;
        logic [31:0] count_at_measure;
        logic [31:0] time_at_measure;
        logic [31:0] rate_held;
        qcr_out_t    expected_results[$];
        int          error_count;

        function new();
            pulse_count      = '0;
            count_at_measure = '0;
            time_at_measure  = '0;
            rate_held        = '0;
            error_count      = 0;
        endfunction

        // rate in pulses per second, truncated toward zero, then saturated
        function logic [31:0] pulses_per_second(logic [31:0] delta_bits,
                                                logic [31:0] interval);
            longint delta_l;
            longint quotient;
            delta_l  = longint'($signed(delta_bits));
            quotient = (delta_l * longint'(TICKS_PER_SECOND)) /
                       longint'({32'd0, interval});
            if (quotient > RATE_MAX)
                quotient = RATE_MAX;
            if (quotient < RATE_MIN)
                quotient = RATE_MIN;
            return quotient[31:0];
        endfunction

        function void note_request(qcr_in_t req);
            qcr_out_t    want;
            logic [31:0] interval;
            want = '0;
            case (req.operation)
                OP_CHANGE_A:
                    if (req.level_a != req.level_b)
                        pulse_count = pulse_count + 32'd1;
                    else
                        pulse_count = pulse_count - 32'd1;
                OP_CHANGE_B:
                    if (req.level_a == req.level_b)
                        pulse_count = pulse_count + 32'd1;
                    else
                        pulse_count = pulse_count - 32'd1;
                OP_MEASURE:
                begin
                    interval = req.time_ms - time_at_measure;
                    if (interval == 32'd0)
                    begin
                        rate_held          = '0;
                        want.zero_interval = 1'b1;
                    end
                    else
                    begin
                        rate_held       = pulses_per_second(pulse_count - count_at_measure,
                                                            interval);
                        want.rate_valid = 1'b1;
                    end
                    count_at_measure = pulse_count;
                    time_at_measure  = req.time_ms;
                end
                default:
                    ;
            endcase
            want.position = pulse_count;
            want.rate_pps = rate_held;
            expected_results.push_back(want);
        endfunction

        function void check_result(qcr_out_t got);
            qcr_out_t want;
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: position %0d", got.position);
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            if (got.position !== want.position)
            begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                error_count++;
            end
            if (got.rate_pps !== want.rate_pps)
            begin
                $error("rate_pps: expected %0d, got %0d", want.rate_pps, got.rate_pps);
                error_count++;
            end
            if (got.rate_valid !== want.rate_valid)
            begin
                $error("rate_valid: expected %0b, got %0b", want.rate_valid, got.rate_valid);
                error_count++;
            end
            if (got.zero_interval !== want.zero_interval)
            begin
                $error("zero_interval: expected %0b, got %0b",
                       want.zero_interval, got.zero_interval);
                error_count++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    qcr_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    qcr_out_t out_data;

    position_rate_tracker tracker;

    // idling knobs, percent of cycles
    int send_idle_pct;
    int recv_stall_pct;
    // set once by the stimulus to start the long receiver hold-off
    bit hold_off_pending;

    quadrature_counter_with_rate_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic qcr_in_t make_request(logic [1:0] op, logic a, logic b,
                                             logic [31:0] t);
        qcr_in_t req;
        req.operation = op;
        req.level_a   = a;
        req.level_b   = b;
        req.time_ms   = t;
        return req;
    endfunction

    // one well-formed x4 step in the chosen direction, random channel and phase
    function automatic qcr_in_t encoder_step(bit forward);
        logic       a;
        logic [1:0] op;
        a  = 1'($urandom_range(1));
        op = ($urandom_range(1) != 0) ? OP_CHANGE_B : OP_CHANGE_A;
        // A counts up when the levels differ, B counts up when they match
        if (op == OP_CHANGE_A)
            return make_request(op, a, forward ? ~a : a, $urandom);
        return make_request(op, a, forward ? a : ~a, $urandom);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input qcr_in_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_request(req);
        @(negedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    initial
    begin
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                repeat (HOLD_OFF_CYCLES)
                begin
                    out_ready <= 1'b0;
                    @(negedge clk);
                end
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
                @(negedge clk);
            end
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(out_data);
    end

    initial
    begin
        int          phase;
        int          i;
        int          sel;
        int          run_left;
        bit          forward;
        logic [31:0] stim_time;
        logic [31:0] t;

        tracker          = new();
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        in_data          = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_pending = 1'b0;
        run_left         = 0;
        forward          = 1'b1;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part
        // measure right after reset, same timestamp as reset: zero interval
        send_request(make_request(OP_MEASURE, 1'b0, 1'b0, 32'd0));
        // every level pair on both channels; the first step wraps the count below zero
        send_request(make_request(OP_CHANGE_A, 1'b0, 1'b0, 32'hFFFF_FFFF));
        send_request(make_request(OP_CHANGE_A, 1'b0, 1'b1, 32'd0));
        send_request(make_request(OP_CHANGE_A, 1'b1, 1'b0, 32'hFFFF_FFFF));
        send_request(make_request(OP_CHANGE_A, 1'b1, 1'b1, 32'd0));
        send_request(make_request(OP_CHANGE_B, 1'b0, 1'b0, 32'hFFFF_FFFF));
        send_request(make_request(OP_CHANGE_B, 1'b0, 1'b1, 32'd0));
        send_request(make_request(OP_CHANGE_B, 1'b1, 1'b0, 32'hFFFF_FFFF));
        send_request(make_request(OP_CHANGE_B, 1'b1, 1'b1, 32'd0));
        // unused code leaves everything alone
        send_request(make_request(OP_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF));
        // shortest interval with no movement
        send_request(make_request(OP_MEASURE, 1'b1, 1'b1, 32'd1));
        // seven steps back over three ms: negative rate truncated toward zero
        repeat (7)
            send_request(make_request(OP_CHANGE_A, 1'b1, 1'b1, 32'd0));
        send_request(make_request(OP_MEASURE, 1'b0, 1'b1, 32'd4));
        // timestamp runs past the top and wraps
        send_request(make_request(OP_MEASURE, 1'b1, 1'b0, 32'hFFFF_FFF0));
        send_request(make_request(OP_CHANGE_A, 1'b1, 1'b0, 32'd0));
        send_request(make_request(OP_MEASURE, 1'b0, 1'b0, 32'd5));
        // largest interval, one step: rate truncates to zero
        send_request(make_request(OP_CHANGE_B, 1'b1, 1'b1, 32'd0));
        send_request(make_request(OP_MEASURE, 1'b0, 1'b0, 32'd4));
        // same timestamp again
        send_request(make_request(OP_MEASURE, 1'b1, 1'b1, 32'd4));
        stim_time = 32'd4;

        // random part, one idling setting per phase
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                3: begin send_idle_pct = 24; recv_stall_pct = 24; end
                default:
                begin
                    // receiver holds off while requests keep coming
                    send_idle_pct    = 0;
                    recv_stall_pct   = 0;
                    hold_off_pending = 1'b1;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (run_left == 0)
                begin
                    forward  = 1'($urandom_range(1));
                    run_left = $urandom_range(1, 30);
                end
                sel = $urandom_range(99);
                if (sel < 8)
                begin
                    // mostly short intervals so bursts give sizable rates
                    case ($urandom_range(9))
                        0:       t = stim_time;
                        1:       t = $urandom;
                        2:       t = stim_time - 32'($urandom_range(1, 8));
                        default: t = stim_time + 32'($urandom_range(1, 40));
                    endcase
                    stim_time = t;
                    send_request(make_request(OP_MEASURE, 1'($urandom_range(1)),
                                              1'($urandom_range(1)), t));
                end
                else if (sel < 10)
                    send_request(make_request(OP_UNUSED, 1'($urandom_range(1)),
                                              1'($urandom_range(1)), $urandom));
                else if (sel < 20)
                    // noise: any channel, any levels
                    send_request(make_request(2'($urandom_range(1)), 1'($urandom_range(1)),
                                              1'($urandom_range(1)), $urandom));
                else
                begin
                    send_request(encoder_step(forward));
                    run_left--;
                end
            end
        end

        in_valid <= 1'b0;
        // drain: all results back, then a measure's worth of quiet cycles
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== quadrature_counter_with_rate_unit.f =====
sv/qcr_pkg.sv
sv/qcr_ctrl.sv
sv/qcr_dp.sv
sv/quadrature_counter_with_rate_unit.sv
sv/qcr_checker.sv
bench/tb_top.sv
